>>> rtl/uer_pkg.sv
package uer_pkg;

  // sizing
  localparam int NUM_SENSORS = 5;
  localparam int COUNT_WIDTH = 32;
  localparam int CNT_IDX_W   = $clog2(COUNT_WIDTH);
  localparam int CH_W        = 3;
  localparam int ECHO_W      = 5;
  localparam int TRIG_W      = 5;
  localparam int DIST_W      = 16;
  localparam int TTICK_W     = 32;
  localparam int TPMM_W      = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  // reset values of the configuration registers
  localparam logic [TTICK_W-1:0] TRIGGER_TICKS_RST = TTICK_W'(2000);
  localparam logic [TPMM_W-1:0]  TICKS_PER_MM_RST  = TPMM_W'(5844);
  localparam logic [DIST_W-1:0]  DIST_MAX          = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MM  = 1'b1;

  // input operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PULSE,
    ST_WAIT,
    ST_MEASURE,
    ST_DIVIDE
  } uer_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_start;
    logic pulse_inc;
    logic echo_set;
    logic echo_inc;
    logic div_start;
    logic emit;
    logic res_pulse;
    logic res_busy;
    logic res_done;
    logic res_bad;
  } uer_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pulse_done;
    logic echo_hi;
    logic chan_bad;
    logic div_done;
    logic out_blocked;
  } uer_sts_t;

endpackage

>>> rtl/uer_div.sv
module uer_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [uer_pkg::COUNT_WIDTH-1:0]    dividend,
  input  logic [uer_pkg::TPMM_W-1:0]         divisor,
  output logic                               done,
  output logic [uer_pkg::COUNT_WIDTH-1:0]    quotient
);

  logic [uer_pkg::COUNT_WIDTH-1:0] quo_r;
  logic [uer_pkg::TPMM_W:0]        rem_r;
  logic [uer_pkg::TPMM_W:0]        rem_nxt;
  logic [uer_pkg::TPMM_W:0]        rem_shift;
  logic [uer_pkg::TPMM_W-1:0]      divisor_r;
  logic [uer_pkg::CNT_IDX_W-1:0]   cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic                            ge;

  // one restoring step per cycle, a zero divisor yields all ones
  assign rem_shift = {rem_r[uer_pkg::TPMM_W-1:0], quo_r[uer_pkg::COUNT_WIDTH-1]};
  assign ge        = rem_shift >= {1'b0, divisor_r};
  assign rem_nxt   = ge ? (rem_shift - {1'b0, divisor_r}) : rem_shift;

  // iteration control, done holds until the next start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == uer_pkg::CNT_IDX_W'(uer_pkg::COUNT_WIDTH - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r     <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[uer_pkg::COUNT_WIDTH-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/uer_ctrl.sv
module uer_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_stall,
  input  uer_pkg::uer_sts_t sts,
  output uer_pkg::uer_cmd_t cmd
);

  uer_pkg::uer_state_t state_r;
  uer_pkg::uer_state_t state_nxt;
  logic                acc;
  logic                start_ok;

  assign in_stall = (state_r == uer_pkg::ST_DIVIDE) || sts.out_blocked;
  assign acc      = in_valid && !in_stall;
  assign start_ok = (in_op == uer_pkg::OP_START) && !sts.chan_bad;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uer_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      uer_pkg::ST_IDLE: begin
        if (acc && start_ok) state_nxt = uer_pkg::ST_PULSE;
      end
      uer_pkg::ST_PULSE: begin
        if (acc && sts.pulse_done) state_nxt = uer_pkg::ST_WAIT;
      end
      uer_pkg::ST_WAIT: begin
        if (acc && sts.echo_hi) state_nxt = uer_pkg::ST_MEASURE;
      end
      uer_pkg::ST_MEASURE: begin
        if (acc && !sts.echo_hi) state_nxt = uer_pkg::ST_DIVIDE;
      end
      uer_pkg::ST_DIVIDE: begin
        if (sts.div_done && !sts.out_blocked) state_nxt = uer_pkg::ST_IDLE;
      end
      default: state_nxt = uer_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      uer_pkg::ST_IDLE: begin
        cmd.load_start = acc && start_ok;
        cmd.emit       = acc;
        cmd.res_pulse  = start_ok;
        cmd.res_busy   = start_ok;
        cmd.res_bad    = (in_op == uer_pkg::OP_START) && sts.chan_bad;
      end
      uer_pkg::ST_PULSE: begin
        cmd.pulse_inc = acc && !sts.pulse_done;
        cmd.emit      = acc;
        cmd.res_pulse = !sts.pulse_done;
        cmd.res_busy  = 1'b1;
      end
      uer_pkg::ST_WAIT: begin
        cmd.echo_set = acc && sts.echo_hi;
        cmd.emit     = acc;
        cmd.res_busy = 1'b1;
      end
      uer_pkg::ST_MEASURE: begin
        // echo low ends the item in the divider, result comes later
        cmd.echo_inc  = acc && sts.echo_hi;
        cmd.div_start = acc && !sts.echo_hi;
        cmd.emit      = acc && sts.echo_hi;
        cmd.res_busy  = 1'b1;
      end
      uer_pkg::ST_DIVIDE: begin
        // wait for a free output register before writing the distance
        cmd.emit     = sts.div_done && !sts.out_blocked;
        cmd.res_done = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/uer_dp.sv
module uer_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [uer_pkg::CH_W-1:0]          in_channel,
  input  logic [uer_pkg::ECHO_W-1:0]        in_echo,
  input  logic                              cfg_valid,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                              cfg_ready,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [uer_pkg::TRIG_W-1:0]        out_trigger,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic [uer_pkg::DIST_W-1:0]        out_distance_mm,
  output logic                              out_bad_channel,
  input  uer_pkg::uer_cmd_t                 cmd,
  output uer_pkg::uer_sts_t                 sts
);

  logic [uer_pkg::TTICK_W-1:0]     trigger_ticks_r;
  logic [uer_pkg::TPMM_W-1:0]      ticks_per_mm_r;
  logic [uer_pkg::CH_W-1:0]        chan_r;
  logic [uer_pkg::CH_W-1:0]        chan_nxt;
  logic [uer_pkg::TTICK_W-1:0]     pulse_cnt_r;
  logic [uer_pkg::COUNT_WIDTH-1:0] echo_cnt_r;
  logic [uer_pkg::TTICK_W-1:0]     limit;
  logic [uer_pkg::ECHO_W-1:0]      echo_shift;
  logic [uer_pkg::COUNT_WIDTH-1:0] quotient;
  logic [uer_pkg::DIST_W-1:0]      dist_sat;
  logic [uer_pkg::TRIG_W-1:0]      trig_nxt;
  logic                            div_done;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic [uer_pkg::TRIG_W-1:0]      trig_r;
  logic                            busy_r;
  logic                            done_r;
  logic [uer_pkg::DIST_W-1:0]      dist_r;
  logic                            bad_r;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= uer_pkg::TRIGGER_TICKS_RST;
      ticks_per_mm_r  <= uer_pkg::TICKS_PER_MM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        uer_pkg::REG_TRIGGER_TICKS: trigger_ticks_r <= cfg_wdata;
        uer_pkg::REG_TICKS_PER_MM:  ticks_per_mm_r  <= cfg_wdata[uer_pkg::TPMM_W-1:0];
        default: ;
      endcase
    end
  end

  // status toward the controller
  assign limit      = (trigger_ticks_r == '0) ? uer_pkg::TTICK_W'(1) : trigger_ticks_r;
  assign echo_shift = in_echo >> chan_r;

  assign sts.pulse_done  = pulse_cnt_r >= limit;
  assign sts.echo_hi     = echo_shift[0];
  assign sts.chan_bad    = in_channel >= uer_pkg::CH_W'(uer_pkg::NUM_SENSORS);
  assign sts.div_done    = div_done;
  assign sts.out_blocked = out_valid_r && out_stall;

  // channel and tick counters
  assign chan_nxt = cmd.load_start ? in_channel : chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r      <= '0;
      pulse_cnt_r <= '0;
      echo_cnt_r  <= '0;
    end else begin
      chan_r <= chan_nxt;
      if (cmd.load_start) begin
        pulse_cnt_r <= uer_pkg::TTICK_W'(1);
        echo_cnt_r  <= '0;
      end else begin
        if (cmd.pulse_inc) pulse_cnt_r <= pulse_cnt_r + 1'b1;
        if (cmd.echo_set) begin
          echo_cnt_r <= uer_pkg::COUNT_WIDTH'(1);
        end else if (cmd.echo_inc && (echo_cnt_r != '1)) begin
          echo_cnt_r <= echo_cnt_r + 1'b1;
        end
      end
    end
  end

  // echo count over ticks per millimetre
  uer_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (echo_cnt_r),
    .divisor  (ticks_per_mm_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign dist_sat = (quotient > uer_pkg::COUNT_WIDTH'(uer_pkg::DIST_MAX)) ?
                    uer_pkg::DIST_MAX : quotient[uer_pkg::DIST_W-1:0];
  assign trig_nxt = cmd.res_pulse ? (uer_pkg::TRIG_W'(1) << chan_nxt) : '0;

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      trig_r <= trig_nxt;
      busy_r <= cmd.res_busy;
      done_r <= cmd.res_done;
      dist_r <= cmd.res_done ? dist_sat : '0;
      bad_r  <= cmd.res_bad;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_trigger     = trig_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_distance_mm = dist_r;
  assign out_bad_channel = bad_r;

endmodule

>>> rtl/ultrasonic_echo_ranger_top.sv
// an accepted tick item's result sits in the output register in the cycle after it is taken
// throughput: one tick item per cycle while the output side keeps up and no division runs
// the tick that ends a measurement runs the bit-serial divider: its result is written
//   once the divider is done and the output register is free, and no further item is
//   taken until then
// reset: synchronous active-low rst_n; control and config registers return to defaults, ranging idle
module ultrasonic_echo_ranger_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [uer_pkg::CH_W-1:0]          in_channel,
  input  logic [uer_pkg::ECHO_W-1:0]        in_echo,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [uer_pkg::TRIG_W-1:0]        out_trigger,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic [uer_pkg::DIST_W-1:0]        out_distance_mm,
  output logic                              out_bad_channel,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  uer_pkg::uer_cmd_t cmd;
  uer_pkg::uer_sts_t sts;

  // ranging sequencer
  uer_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // counters, divider, config and output register
  uer_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_channel      (in_channel),
    .in_echo         (in_echo),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cfg_ready       (cfg_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_trigger     (out_trigger),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_distance_mm (out_distance_mm),
    .out_bad_channel (out_bad_channel),
    .cmd             (cmd),
    .sts             (sts)
  );

`ifndef ASSERT_OFF
  // a new result never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_blocked)
    else $error("result written over a pending item");

  // at most one trigger line high
  a_trig_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_trigger))
    else $error("more than one trigger line high");

  // a finished measurement leaves the block idle with triggers low
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (!out_busy_res && out_trigger == '0))
    else $error("done reported while still busy");

  // divider start always stalls the following input
  a_div_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> in_stall)
    else $error("input taken while dividing");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import uer_pkg::*;

  localparam int WATCH_LIMIT = 4000;

  // ranging phases as seen from the pins
  typedef enum logic [1:0] {
    RNG_IDLE,
    RNG_PULSE,
    RNG_WAIT,
    RNG_MEASURE
  } rng_phase_t;

  // one result item
  typedef struct packed {
    logic [TRIG_W-1:0] trigger;
    logic              busy;
    logic              done;
    logic [DIST_W-1:0] distance;
    logic              bad;
  } reading_t;

  // predicts each reading from the accepted ticks and checks the block against it
  class ranger_scoreboard;
    logic [TTICK_W-1:0]     pulse_len;
    logic [TPMM_W-1:0]      mm_div;
    rng_phase_t             phase;
    logic [CH_W-1:0]        act_ch;
    logic [TTICK_W-1:0]     pulse_cnt;
    logic [COUNT_WIDTH-1:0] echo_cnt;
    reading_t               pending_readings[$];
    int                     errors;

    function new();
      pulse_len = TRIGGER_TICKS_RST;
      mm_div    = TICKS_PER_MM_RST;
      phase     = RNG_IDLE;
      act_ch    = '0;
      pulse_cnt = '0;
      echo_cnt  = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TRIGGER_TICKS: pulse_len = data[TTICK_W-1:0];
        REG_TICKS_PER_MM:  mm_div = data[TPMM_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the ranging state by one tick and queue the reading it yields
    function void note_tick(logic op, logic [CH_W-1:0] ch, logic [ECHO_W-1:0] echo);
      reading_t               r;
      logic [TTICK_W-1:0]     limit;
      logic [COUNT_WIDTH-1:0] quot;
      logic                   echo_hi;
      r       = '0;
      limit   = (pulse_len == '0) ? TTICK_W'(1) : pulse_len;
      echo_hi = |((echo >> act_ch) & ECHO_W'(1));
      case (phase)
        RNG_IDLE: begin
          if (op == OP_START) begin
            if (ch >= NUM_SENSORS) begin
              r.bad = 1'b1;
            end else begin
              act_ch    = ch;
              pulse_cnt = TTICK_W'(1);
              echo_cnt  = '0;
              phase     = RNG_PULSE;
            end
          end
        end
        RNG_PULSE: begin
          if (pulse_cnt >= limit) phase = RNG_WAIT;
          else pulse_cnt = pulse_cnt + 1'b1;
        end
        RNG_WAIT: begin
          if (echo_hi) begin
            echo_cnt = COUNT_WIDTH'(1);
            phase    = RNG_MEASURE;
          end
        end
        default: begin
          if (echo_hi) begin
            // count saturates rather than wraps
            if (echo_cnt != '1) echo_cnt = echo_cnt + 1'b1;
          end else begin
            // zero divisor reads as full scale
            quot = (mm_div == '0) ? COUNT_WIDTH'(DIST_MAX) : echo_cnt / mm_div;
            r.distance = (quot > DIST_MAX) ? DIST_MAX : quot[DIST_W-1:0];
            r.done     = 1'b1;
            phase      = RNG_IDLE;
          end
        end
      endcase
      if (phase == RNG_PULSE) r.trigger = TRIG_W'(1) << act_ch;
      r.busy = (phase != RNG_IDLE);
      pending_readings.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result trigger %h busy %b done %b distance %h bad %b",
                 $time, got.trigger, got.busy, got.done, got.distance, got.bad);
        errors++;
        return;
      end
      want = pending_readings.pop_front();
      cmp_field("trigger", 32'(want.trigger), 32'(got.trigger));
      cmp_field("busy_res", 32'(want.busy), 32'(got.busy));
      cmp_field("done_res", 32'(want.done), 32'(got.done));
      cmp_field("distance_mm", 32'(want.distance), 32'(got.distance));
      cmp_field("bad_channel", 32'(want.bad), 32'(got.bad));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic [CH_W-1:0]       in_channel;
  logic [ECHO_W-1:0]     in_echo;
  logic                  out_valid;
  logic                  out_stall;
  logic [TRIG_W-1:0]     out_trigger;
  logic                  out_busy_res;
  logic                  out_done_res;
  logic [DIST_W-1:0]     out_distance_mm;
  logic                  out_bad_channel;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ranger_scoreboard sb = new();
  bit               gap_on;
  int unsigned      items_sent;
  int unsigned      idle_cycles;
  reading_t         got;

  ultrasonic_echo_ranger_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_channel      (in_channel),
    .in_echo         (in_echo),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_trigger     (out_trigger),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_distance_mm (out_distance_mm),
    .out_bad_channel (out_bad_channel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sender gap length: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gap_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // mostly plain ticks, now and then a start that lands while busy
  function automatic logic pick_op();
    return ($urandom_range(0, 7) == 0) ? OP_START : OP_TICK;
  endfunction

  function automatic logic [ECHO_W-1:0] echo_with(logic [CH_W-1:0] ch, logic lvl);
    logic [ECHO_W-1:0] e;
    e     = ECHO_W'($urandom_range(0, 31));
    e[ch] = lvl;
    return e;
  endfunction

  task automatic send_item(input logic op, input logic [CH_W-1:0] ch,
                           input logic [ECHO_W-1:0] echo);
    int unsigned gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_op      <= op;
    in_channel <= ch;
    in_echo    <= echo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(op, ch, echo);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drop valid and wait for every outstanding reading
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // walk any ranging in progress back to idle
  task automatic close_measurement();
    while (sb.phase == RNG_PULSE)
      send_item(OP_TICK, CH_W'($urandom_range(0, 7)), ECHO_W'($urandom_range(0, 31)));
    if (sb.phase == RNG_WAIT) send_item(OP_TICK, sb.act_ch, echo_with(sb.act_ch, 1'b1));
    if (sb.phase == RNG_MEASURE) send_item(OP_TICK, sb.act_ch, echo_with(sb.act_ch, 1'b0));
  endtask

  // one well-formed ranging: start, pulse, quiet echo, echo high, echo falls
  task automatic measure(input logic [CH_W-1:0] ch, input int unsigned wait_len,
                         input int unsigned high_len);
    close_measurement();
    send_item(OP_START, ch, ECHO_W'($urandom_range(0, 31)));
    while (sb.phase == RNG_PULSE)
      send_item(pick_op(), CH_W'($urandom_range(0, 7)), ECHO_W'($urandom_range(0, 31)));
    repeat (wait_len) send_item(pick_op(), CH_W'($urandom_range(0, 7)), echo_with(ch, 1'b0));
    repeat (high_len) send_item(pick_op(), CH_W'($urandom_range(0, 7)), echo_with(ch, 1'b1));
    send_item(pick_op(), CH_W'($urandom_range(0, 7)), echo_with(ch, 1'b0));
  endtask

  task automatic noise_burst(input int unsigned n);
    repeat (n)
      send_item(logic'($urandom_range(0, 1)), CH_W'($urandom_range(0, 7)),
                ECHO_W'($urandom_range(0, 31)));
  endtask

  // receiver stalls: quiet windows, short bursts, rare long holds
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned hold;
    out_stall = 1'b0;
    hold      = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        if (hold > 0) begin
          hold--;
          out_stall <= 1'b1;
        end else if (mode == 1 && $urandom_range(0, 3) == 0) begin
          hold = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else if (mode == 2 && $urandom_range(0, 24) == 0) begin
          hold = $urandom_range(8, 40);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got.trigger  = out_trigger;
      got.busy     = out_busy_res;
      got.done     = out_done_res;
      got.distance = out_distance_mm;
      got.bad      = out_bad_channel;
      sb.check_reading(got);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int unsigned target;
    int unsigned p;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = OP_TICK;
    in_channel  = '0;
    in_echo     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_TRIGGER_TICKS;
    cfg_wdata   = '0;
    gap_on      = 1'b1;
    items_sent  = 0;
    idle_cycles = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: idle corners, invalid channels, start of the default pulse
    send_item(OP_TICK, CH_W'(0), ECHO_W'(0));
    send_item(OP_TICK, CH_W'(7), ECHO_W'(5'h1F));
    send_item(OP_START, CH_W'(5), ECHO_W'(0));
    send_item(OP_START, CH_W'(7), ECHO_W'(5'h1F));
    send_item(OP_START, CH_W'(6), ECHO_W'(5'h0A));
    send_item(OP_START, CH_W'(0), ECHO_W'($urandom_range(0, 31)));
    repeat (40)
      send_item(pick_op(), CH_W'($urandom_range(0, 7)), ECHO_W'($urandom_range(0, 31)));

    // shorten the pulse mid-ranging, default divisor still in place
    settle();
    set_reg(REG_TRIGGER_TICKS, 32'h2);
    close_measurement();
    gap_on = 1'b0;
    measure(CH_W'(0), 3, 40);

    // zero pulse length acts as one tick, zero divisor reads full scale
    settle();
    gap_on = 1'b1;
    set_reg(REG_TRIGGER_TICKS, 32'h0);
    set_reg(REG_TICKS_PER_MM, 32'h0);
    measure(CH_W'(4), 0, 1);
    measure(CH_W'(2), 2, 5);

    // unit divisor, distance equals the echo count
    settle();
    set_reg(REG_TRIGGER_TICKS, 32'h1);
    set_reg(REG_TICKS_PER_MM, {16'($urandom), 16'd1});
    gap_on = 1'b0;
    measure(CH_W'(1), 1, 60);
    gap_on = 1'b1;
    measure(CH_W'(3), 0, 1);

    // largest divisor
    settle();
    set_reg(REG_TRIGGER_TICKS, 32'h3);
    set_reg(REG_TICKS_PER_MM, {16'($urandom), 16'hFFFF});
    measure(CH_W'(3), 1, 40);

    // random rangings under a handful of short settings
    for (p = 0; p < 6; p++) begin
      settle();
      set_reg(REG_TRIGGER_TICKS, (p == 2) ? 32'h0 : 32'($urandom_range(1, 6)));
      set_reg(REG_TICKS_PER_MM, {16'($urandom), 16'($urandom_range(1, 12))});
      target = items_sent + 60;
      while (items_sent < target) begin
        gap_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
          0, 1, 2: noise_burst($urandom_range(1, 8));
          3: settle();
          default: measure(CH_W'($urandom_range(0, 4)), $urandom_range(0, 5),
                           ($urandom_range(0, 4) == 0) ? $urandom_range(31, 200)
                                                       : $urandom_range(1, 30));
        endcase
      end
      close_measurement();
    end

    // longest pulse: the run ends with the trigger still high
    settle();
    gap_on = 1'b1;
    set_reg(REG_TRIGGER_TICKS, 32'hFFFF_FFFF);
    send_item(OP_START, CH_W'($urandom_range(0, 4)), ECHO_W'($urandom_range(0, 31)));
    noise_burst(30);

    settle();
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/uer_pkg.sv
rtl/uer_div.sv
rtl/uer_ctrl.sv
rtl/uer_dp.sv
rtl/ultrasonic_echo_ranger_top.sv
tb/sv/testbench.sv
